// ----- hdl/sorted_list_engine_assert.svh -----
// assertion macros for the sorted list engine checker
`ifndef SORTED_LIST_ENGINE_ASSERT_SVH
`define SORTED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SLE_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sorted list engine: implication check failed");

// next-cycle implication, disabled in reset
`define SLE_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sorted list engine: next-cycle check failed");

`endif

// ----- hdl/sle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  localparam int DEPTH    = 16;
  localparam int VALUE_W  = 32;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int OCC_W    = 5;

  typedef enum logic [1:0] {
    ACT_HEAD  = 2'd0,
    ACT_TAIL  = 2'd1,
    ACT_ORDER = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_ELEMENT  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    action_t                    action;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  element;
    logic                       last;
    logic [OCC_W-1:0]           occupancy;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    cmp;
    logic    ins;
    logic    emit;
    status_t emit_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/sle_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sle_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire sle_pkg::action_t in_action,
  output logic                 in_stall,
  input  wire sle_pkg::sts_t   sts,
  output sle_pkg::cmd_t        cmd
);
  import sle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_INS,
    S_RESP,
    S_READ
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t resp_status;
  status_t resp_status_next;

  assign in_stall = rst | (state != S_IDLE);

  always_comb begin
    state_next       = state;
    resp_status_next = resp_status;
    cmd              = '0;
    cmd.emit_status  = resp_status;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (in_action == ACT_READ) begin
            if (sts.cnt_zero) begin
              resp_status_next = ST_EMPTY;
              state_next       = S_RESP;
            end else begin
              state_next = S_READ;
            end
          end else if (sts.cnt_full) begin
            resp_status_next = ST_FULL;
            state_next       = S_RESP;
          end else begin
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_INS;
      end
      S_INS: begin
        cmd.ins          = 1'b1;
        resp_status_next = ST_INSERTED;
        state_next       = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        cmd.emit_status = ST_ELEMENT;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.rd_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      resp_status <= ST_INSERTED;
    end else begin
      state       <= state_next;
      resp_status <= resp_status_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sle_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sle_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sle_pkg::in_item_t in_item,
  input  wire sle_pkg::cmd_t     cmd,
  output sle_pkg::sts_t          sts,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sle_pkg::out_item_t     out_item
);
  import sle_pkg::*;

  logic signed [VALUE_W-1:0] cells [DEPTH];
  action_t                   act;
  logic signed [VALUE_W-1:0] val;
  logic [CNT_W-1:0]          count;
  logic [IDX_W-1:0]          idx;
  logic [DEPTH-1:0]          flags;
  logic [DEPTH-1:0]          flags_next;
  logic [DEPTH-1:0]          pos_hot;
  logic [DEPTH-1:0]          at_or_after;

  assign sts.cnt_zero = (count == '0);
  assign sts.cnt_full = (count == CNT_W'(DEPTH));
  assign sts.rd_last  = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign sts.out_free = !out_valid || !out_stall;

  // per-cell insert candidates, the first set bit is the insert position
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      case (act)
        ACT_HEAD:  flags_next[i] = 1'b1;
        ACT_TAIL:  flags_next[i] = (CNT_W'(i) >= count);
        ACT_ORDER: flags_next[i] = (CNT_W'(i) >= count) || (cells[i] >= val);
        default:   flags_next[i] = 1'b0;
      endcase
    end
  end

  assign pos_hot     = flags & (~flags + DEPTH'(1));
  assign at_or_after = ~(pos_hot - DEPTH'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act <= in_item.action;
      val <= in_item.value;
    end
    if (cmd.cmp) begin
      flags <= flags_next;
    end
    if (cmd.ins) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (pos_hot[i]) begin
          cells[i] <= val;
        end else if (at_or_after[i] && i > 0) begin
          cells[i] <= cells[(i > 0) ? i - 1 : 0];
        end
      end
    end
    if (cmd.emit) begin
      out_item.status    <= cmd.emit_status;
      out_item.occupancy <= OCC_W'(count);
      if (cmd.emit_status == ST_ELEMENT) begin
        out_item.element <= cells[idx];
        out_item.last    <= sts.rd_last;
      end else begin
        out_item.element <= '0;
        out_item.last    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ins) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.load_in) begin
        idx <= '0;
      end else if (cmd.emit && cmd.emit_status == ST_ELEMENT) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sorted_list_engine.sv -----
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------------
// in        | in_valid / in_stall       | in_item  (action, value)
// out       | out_valid / out_stall     | out_item (status, element, last, occupancy)
//
// head, tail and in-order inserts step through accept, compare, shift, result
// an insert into a full list and a read-out of an empty list go from accept to result
// a read-out gives one stored value per cycle unless stalled, from a 16:1 cell mux
// output stalls hold the controller; a new item is taken while the last result waits
// reset empties the list; stored values are not cleared
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sle_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sle_pkg::out_item_t      out_item
);
  import sle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_item.action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sle_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- hdl/sle_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_list_engine_assert.svh"

module sle_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire sle_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire sle_pkg::out_item_t out_item
);
  import sle_pkg::*;

  logic in_xact;
  logic out_held;
  logic plain_out;

  assign in_xact   = in_valid && !in_stall;
  assign out_held  = out_valid && out_stall;
  assign plain_out = out_valid && (out_item.status != ST_ELEMENT);

  // a stalled result stays put
  `SLE_ASSERT_NEXT(a_out_hold, clk, rst, out_held, out_valid && $stable(out_item))

  // one item in work at a time
  `SLE_ASSERT_NEXT(a_in_busy, clk, rst, in_xact, in_stall)

  // only element results carry data
  `SLE_ASSERT_IMPLY(a_elem_zero, clk, rst, plain_out, out_item.element == '0)

  // single-result transactions always close
  `SLE_ASSERT_IMPLY(a_single_last, clk, rst, plain_out, out_item.last)

endmodule

bind sorted_list_engine sle_checker u_sle_checker (.*);

`default_nettype wire
